// ===== rtl/periodic_task_timer_table_core_macros.svh =====
// Assertion macros used by the port-level checker
`ifndef PERIODIC_TASK_TIMER_TABLE_CORE_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset
`define PTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle
`define PTT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg
// Types and codes shared by the periodic task timer table modules.
// ----------------------------------------------------------------------------
package ptt_pkg;
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_REMOVE = 3'd1, CMD_GET = 3'd2, CMD_UPDATE = 3'd3, CMD_POP = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOT_FOUND = 3'd1, ST_TABLE_FULL = 3'd2,
    ST_QUEUE_EMPTY = 3'd3, ST_QUEUE_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_EXEC, S_UPD_SCAN, S_UPD_RD, S_UPD_WR, S_POP_RD, S_POP_WAIT, S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input transaction
    logic scan_clr;   // restart slot scan
    logic scan_step;  // examine one slot
    logic exec;       // apply add/remove/get/unknown, flag empty pop
    logic upd_clr;    // start a new minimum search
    logic upd_pick;   // mark chosen slot done
    logic upd_apply;  // push copy and reschedule
    logic pop_take;   // take queue head
    logic out_load;   // present result
  } ptt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic scan_last;
    logic upd_found;
    logic q_empty;
  } ptt_sts_t;
endpackage

// ===== rtl/ptt_ram.sv =====
// ----------------------------------------------------------------------------
// ptt_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/ptt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer: slot scan for add/remove/get, repeated minimum search for update,
// queue read for pop, then result hand-off.
// ----------------------------------------------------------------------------
module ptt_ctrl import ptt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  ptt_sts_t sts,
  output ptt_cmd_t cmd
);
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_SCAN;
      S_SCAN: begin
        if (sts.cmd == CMD_UPDATE) state_nxt = S_UPD_SCAN;
        else if (sts.cmd == CMD_POP) state_nxt = sts.q_empty ? S_DONE : S_POP_RD;
        else if (sts.scan_last) state_nxt = S_EXEC;
      end
      S_EXEC:     state_nxt = S_DONE;
      S_UPD_SCAN: if (sts.scan_last) state_nxt = sts.upd_found ? S_UPD_RD : S_DONE;
      S_UPD_RD:   state_nxt = S_UPD_WR;
      S_UPD_WR:   state_nxt = S_UPD_SCAN;
      S_POP_RD:   state_nxt = S_POP_WAIT;
      S_POP_WAIT: state_nxt = S_DONE;
      S_DONE:     if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        cmd.scan_clr = in_valid;
      end
      S_SCAN: begin
        cmd.scan_step = (sts.cmd != CMD_UPDATE) && (sts.cmd != CMD_POP);
        cmd.upd_clr   = (sts.cmd == CMD_UPDATE);
        cmd.exec      = (sts.cmd == CMD_POP) && sts.q_empty;
      end
      S_EXEC:     cmd.exec = 1'b1;
      S_UPD_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.upd_pick  = sts.scan_last && sts.upd_found;
      end
      S_UPD_RD:   ;
      S_UPD_WR: begin
        cmd.upd_apply = 1'b1;
        cmd.upd_clr   = 1'b1;
      end
      S_POP_RD:   ;
      S_POP_WAIT: cmd.pop_take = 1'b1;
      S_DONE: if (!out_valid_r || !out_stall) begin
        cmd.out_load  = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/ptt_dp.sv =====
// ----------------------------------------------------------------------------
// ptt_dp
// Datapath: task slot registers, id counter, ready queue RAM, result register.
// ----------------------------------------------------------------------------
module ptt_dp import ptt_pkg::*; #(
  parameter int TASK_SLOTS  = 16,
  parameter int READY_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ptt_cmd_t    cmd,
  output ptt_sts_t    sts,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_task_id,
  input  logic [63:0] in_period,
  input  logic [63:0] in_time_ms,
  output logic [2:0]  out_status,
  output logic [31:0] out_task_id,
  output logic [63:0] out_period,
  output logic [63:0] out_due_time,
  output logic [$clog2(TASK_SLOTS+1)-1:0]  out_task_count,
  output logic [$clog2(READY_DEPTH+1)-1:0] out_ready_count
);
  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int QW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int FW = $clog2(READY_DEPTH + 1);
  localparam int QDW = 32 + 64 + 64;

  // task slots: small, swept one per cycle
  logic        slot_valid_r [TASK_SLOTS];
  logic [31:0] slot_id_r    [TASK_SLOTS];
  logic [63:0] slot_per_r   [TASK_SLOTS];
  logic [63:0] slot_due_r   [TASK_SLOTS];
  logic        done_r       [TASK_SLOTS];

  logic [2:0]  cmd_r;
  logic [31:0] tid_r, idc_r;
  logic [63:0] per_r, tm_r;
  logic [SW-1:0] idx_r;
  logic        hit_r, free_r, best_v_r;
  logic [SW-1:0] hit_idx_r, free_idx_r, best_idx_r;
  logic [31:0] best_id_r;
  logic [CW-1:0] cnt_r;
  logic [QW-1:0] head_r, tail_r;
  logic [FW-1:0] fill_r;
  logic [2:0]  res_st_r;
  logic [31:0] res_id_r;
  logic [63:0] res_per_r, res_due_r;

  logic [31:0] key;
  logic        sel_v;
  logic [SW-1:0] sidx;
  logic [64:0] nx_sum;
  logic [63:0] nx;
  logic        q_we;
  logic [QDW-1:0] q_rdata;
  logic [31:0] idc_inc;

  assign key  = (cmd_r == CMD_ADD) ? idc_r : tid_r;
  assign sidx = best_idx_r;
  assign sel_v = slot_valid_r[idx_r] && !done_r[idx_r] && (slot_due_r[idx_r] <= tm_r);
  assign nx_sum = {1'b0, tm_r} + {1'b0, slot_per_r[sidx]};
  assign nx = nx_sum[64] ? '1 : nx_sum[63:0];
  assign q_we = cmd.upd_apply && (fill_r != FW'(READY_DEPTH));
  assign idc_inc = (idc_r == 32'hFFFF_FFFF) ? 32'd1 : idc_r + 32'd1;

  assign sts.cmd       = cmd_t'(cmd_r);
  assign sts.scan_last = (idx_r == SW'(TASK_SLOTS - 1));
  assign sts.upd_found = best_v_r || sel_v;
  assign sts.q_empty   = (fill_r == '0);

  ptt_ram #(.WIDTH(QDW), .DEPTH(READY_DEPTH)) u_queue (
    .clk(clk), .we(q_we), .waddr(tail_r),
    .wdata({slot_id_r[sidx], slot_per_r[sidx], slot_due_r[sidx]}),
    .raddr(head_r), .rdata(q_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      tid_r <= in_task_id;
      per_r <= in_period;
      tm_r  <= in_time_ms;
    end
    if (cmd.scan_clr) begin
      idx_r  <= '0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.upd_clr) begin
      idx_r    <= '0;
      best_v_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!sts.scan_last) idx_r <= idx_r + SW'(1);
      if (slot_valid_r[idx_r] && slot_id_r[idx_r] == key && !hit_r) begin
        hit_r <= 1'b1;
        hit_idx_r <= idx_r;
      end
      if (!slot_valid_r[idx_r] && !free_r) begin
        free_r <= 1'b1;
        free_idx_r <= idx_r;
      end
      if (sel_v && (!best_v_r || slot_id_r[idx_r] < best_id_r)) begin
        best_v_r   <= 1'b1;
        best_id_r  <= slot_id_r[idx_r];
        best_idx_r <= idx_r;
      end
    end
    if (cmd.out_load) begin
      out_status      <= res_st_r;
      out_task_id     <= res_id_r;
      out_period      <= res_per_r;
      out_due_time    <= res_due_r;
      out_task_count  <= cnt_r;
      out_ready_count <= fill_r;
    end
  end

  // result staging and slot updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_valid_r[i] <= 1'b0;
        done_r[i] <= 1'b0;
      end
      idc_r  <= 32'd1;
      cnt_r  <= '0;
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      if (cmd.load) begin
        for (int i = 0; i < TASK_SLOTS; i++) done_r[i] <= 1'b0;
        res_st_r <= ST_OK;
        res_id_r <= '0;
        res_per_r <= '0;
        res_due_r <= '0;
      end
      if (cmd.exec) begin
        unique case (cmd_r)
          CMD_ADD: begin
            if (hit_r || free_r) begin
              slot_valid_r[hit_r ? hit_idx_r : free_idx_r] <= 1'b1;
              slot_id_r[hit_r ? hit_idx_r : free_idx_r]    <= idc_r;
              slot_per_r[hit_r ? hit_idx_r : free_idx_r]   <= per_r;
              slot_due_r[hit_r ? hit_idx_r : free_idx_r]   <= tm_r;
              if (!hit_r) cnt_r <= cnt_r + CW'(1);
              res_id_r <= idc_r;
              idc_r <= idc_inc;
            end else res_st_r <= ST_TABLE_FULL;
          end
          CMD_REMOVE: begin
            if (hit_r) begin
              slot_valid_r[hit_idx_r] <= 1'b0;
              cnt_r <= cnt_r - CW'(1);
            end else res_st_r <= ST_NOT_FOUND;
          end
          CMD_GET: begin
            if (hit_r) begin
              res_id_r  <= slot_id_r[hit_idx_r];
              res_per_r <= slot_per_r[hit_idx_r];
              res_due_r <= slot_due_r[hit_idx_r];
            end else res_st_r <= ST_NOT_FOUND;
          end
          // only issued for a pop on an empty queue
          CMD_POP: res_st_r <= ST_QUEUE_EMPTY;
          default: ;
        endcase
      end
      if (cmd.upd_pick) done_r[(sel_v && (!best_v_r || slot_id_r[idx_r] < best_id_r))
                               ? idx_r : best_idx_r] <= 1'b1;
      if (cmd.upd_apply) begin
        if (q_we) begin
          tail_r <= (tail_r == QW'(READY_DEPTH - 1)) ? '0 : tail_r + QW'(1);
          fill_r <= fill_r + FW'(1);
        end else res_st_r <= ST_QUEUE_OVERFLOW;
        if (slot_per_r[sidx] != '0) slot_due_r[sidx] <= nx;
        else begin
          slot_valid_r[sidx] <= 1'b0;
          cnt_r <= cnt_r - CW'(1);
        end
      end
      if (cmd.pop_take) begin
        {res_id_r, res_per_r, res_due_r} <= q_rdata;
        head_r <= (head_r == QW'(READY_DEPTH - 1)) ? '0 : head_r + QW'(1);
        fill_r <= fill_r - FW'(1);
      end
    end
  end
endmodule

// ===== rtl/periodic_task_timer_table_core.sv =====
// Add/remove/get/unknown scan every slot, then execute and register the result;
//   pop reads the queue RAM, or on an empty queue goes straight to the result;
//   update repeats the minimum search once per due task, plus a last empty one.
// One transaction at a time; the next is taken the cycle after the result registers.
// The slot scan and the repeated minimum-id search over the slots set the rate.
// Synchronous active-low reset empties the table and queue, id counter to one.
// ----------------------------------------------------------------------------
// periodic_task_timer_table_core
// Task table with id allocation, timed update into a ready queue and pop.
// ----------------------------------------------------------------------------
module periodic_task_timer_table_core import ptt_pkg::*; #(
  parameter int TASK_SLOTS  = 16,
  parameter int READY_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_task_id,
  input  logic [63:0] in_period,
  input  logic [63:0] in_time_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_task_id,
  output logic [63:0] out_period,
  output logic [63:0] out_due_time,
  output logic [$clog2(TASK_SLOTS+1)-1:0]  out_task_count,
  output logic [$clog2(READY_DEPTH+1)-1:0] out_ready_count
);
  ptt_cmd_t c;
  ptt_sts_t s;

  ptt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(s), .cmd(c)
  );

  ptt_dp #(.TASK_SLOTS(TASK_SLOTS), .READY_DEPTH(READY_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(c), .sts(s),
    .in_command(in_command), .in_task_id(in_task_id),
    .in_period(in_period), .in_time_ms(in_time_ms),
    .out_status(out_status), .out_task_id(out_task_id),
    .out_period(out_period), .out_due_time(out_due_time),
    .out_task_count(out_task_count), .out_ready_count(out_ready_count)
  );
endmodule

// ===== rtl/ptt_checker.sv =====
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks on the task timer table, bound to the top level.
// ----------------------------------------------------------------------------
`include "periodic_task_timer_table_core_macros.svh"
module ptt_checker import ptt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status
);
  `PTT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "accept not followed by busy")
  `PTT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status), "stalled result changed")
  `PTT_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, out_status <= ST_QUEUE_OVERFLOW, "bad status code")
endmodule

bind periodic_task_timer_table_core ptt_checker u_ptt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status)
);

// ===== tb/tb_periodic_task_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_periodic_task_timer_table_core
// Drives table commands through the valid/stall channel, predicts each result
// with a behavioural model of the task table and ready queue, and compares.
// ----------------------------------------------------------------------------
module tb_periodic_task_timer_table_core import ptt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int QDEPTH = 32;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] task_id;
    logic [63:0] period;
    logic [63:0] time_ms;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] task_id;
    logic [63:0] period;
    logic [63:0] due_time;
    logic [4:0]  task_count;
    logic [5:0]  ready_count;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_command = '0;
  logic [31:0] in_task_id = '0;
  logic [63:0] in_period = '0;
  logic [63:0] in_time_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [31:0] out_task_id;
  logic [63:0] out_period;
  logic [63:0] out_due_time;
  logic [4:0] out_task_count;
  logic [5:0] out_ready_count;

  periodic_task_timer_table_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_task_id(in_task_id), .in_period(in_period), .in_time_ms(in_time_ms),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_task_id(out_task_id), .out_period(out_period),
    .out_due_time(out_due_time), .out_task_count(out_task_count),
    .out_ready_count(out_ready_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // table model
  logic        tbl_used [SLOTS];
  logic [31:0] tbl_id   [SLOTS];
  logic [63:0] tbl_per  [SLOTS];
  logic [63:0] tbl_due  [SLOTS];
  logic [31:0] next_id;
  logic [31:0] rq_id  [$];
  logic [63:0] rq_per [$];
  logic [63:0] rq_due [$];

  cmd_item_t pending_cmds[$];
  reply_t    expected_replies[$];
  int errors = 0;
  int accepted = 0, replies_seen = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_recv = 0, stim_done = 0;
  logic [63:0] now_ms = 0;

  function automatic int live_tasks();
    int n = 0;
    for (int i = 0; i < SLOTS; i++) if (tbl_used[i]) n++;
    return n;
  endfunction

  function automatic int lookup_task(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++) if (tbl_used[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic reply_t timer_table_step(cmd_item_t c);
    reply_t r;
    int s, best;
    bit seen [SLOTS];
    logic [63:0] nx;
    r = '0;
    case (c.command)
      CMD_ADD: begin
        s = lookup_task(next_id);
        if (s < 0)
          for (int i = 0; i < SLOTS; i++) if (!tbl_used[i]) begin s = i; break; end
        if (s < 0) r.status = ST_TABLE_FULL;
        else begin
          tbl_used[s] = 1; tbl_id[s] = next_id;
          tbl_per[s] = c.period; tbl_due[s] = c.time_ms;
          r.task_id = next_id;
          next_id = next_id + 32'd1;
          if (next_id == 0) next_id = 1;
        end
      end
      CMD_REMOVE, CMD_GET: begin
        s = lookup_task(c.task_id);
        if (s < 0) r.status = ST_NOT_FOUND;
        else if (c.command == CMD_REMOVE) tbl_used[s] = 0;
        else begin
          r.task_id = tbl_id[s]; r.period = tbl_per[s]; r.due_time = tbl_due[s];
        end
      end
      CMD_UPDATE: begin
        foreach (seen[i]) seen[i] = 0;
        forever begin
          best = -1;
          for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i] && !seen[i] && tbl_due[i] <= c.time_ms)
              if (best < 0 || tbl_id[i] < tbl_id[best]) best = i;
          if (best < 0) break;
          seen[best] = 1;
          if (rq_id.size() >= QDEPTH) r.status = ST_QUEUE_OVERFLOW;
          else begin
            rq_id.insert(rq_id.size(), tbl_id[best]);
            rq_per.insert(rq_per.size(), tbl_per[best]);
            rq_due.insert(rq_due.size(), tbl_due[best]);
          end
          if (tbl_per[best] != 0) begin
            nx = c.time_ms + tbl_per[best];
            if (nx < c.time_ms) nx = '1;
            tbl_due[best] = nx;
          end else tbl_used[best] = 0;
        end
      end
      CMD_POP: begin
        if (rq_id.size() == 0) r.status = ST_QUEUE_EMPTY;
        else begin
          r.task_id = rq_id.pop_front(); r.period = rq_per.pop_front();
          r.due_time = rq_due.pop_front();
        end
      end
      default: ;
    endcase
    r.task_count = 5'(live_tasks());
    r.ready_count = 6'(rq_id.size());
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_replies.insert(expected_replies.size(),
                                timer_table_step(pending_cmds.pop_front()));
        accepted++;
      end
      if ((!in_valid || !in_stall) ) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct
            && !(in_valid && !in_stall && pending_cmds.size() == 0)) begin
          in_valid <= 1'b1;
          {in_command, in_task_id, in_period, in_time_ms} <= pending_cmds[0];
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          exp_r = expected_replies.pop_front();
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status); errors++;
          end
          if (out_task_id !== exp_r.task_id) begin
            $error("task_id: expected %0d, got %0d", exp_r.task_id, out_task_id); errors++;
          end
          if (out_period !== exp_r.period) begin
            $error("period: expected %0h, got %0h", exp_r.period, out_period);
            errors++;
          end
          if (out_due_time !== exp_r.due_time) begin
            $error("due_time: expected %0h, got %0h", exp_r.due_time,
                   out_due_time);
            errors++;
          end
          if (out_task_count !== exp_r.task_count) begin
            $error("task_count: expected %0d, got %0d", exp_r.task_count, out_task_count);
            errors++;
          end
          if (out_ready_count !== exp_r.ready_count) begin
            $error("ready_count: expected %0d, got %0d", exp_r.ready_count,
                   out_ready_count);
            errors++;
          end
        end
      end
      out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // mostly ids near those issued so far, so remove/get can hit a live task
  function automatic logic [31:0] pick_id();
    if ($urandom_range(3) == 0) return $urandom();
    return $urandom_range(next_id + 2, (next_id > 20) ? next_id - 20 : 0);
  endfunction

  function automatic cmd_item_t rand_cmd();
    cmd_item_t c;
    int k = $urandom_range(99);
    c.task_id = $urandom();
    c.period = {$urandom(), $urandom()};
    c.time_ms = {$urandom(), $urandom()};
    if (k < 30) begin
      c.command = CMD_ADD;
      case ($urandom_range(3))
        0: c.period = '0;
        1, 2: c.period = 64'($urandom_range(50));
        default: ;
      endcase
      if ($urandom_range(3) != 0) c.time_ms = now_ms + 64'($urandom_range(60));
    end else if (k < 40) begin
      c.command = CMD_REMOVE; c.task_id = pick_id();
    end else if (k < 52) begin
      c.command = CMD_GET; c.task_id = pick_id();
    end else if (k < 70) begin
      c.command = CMD_UPDATE;
      now_ms = now_ms + 64'($urandom_range(30));
      if ($urandom_range(15) != 0) c.time_ms = now_ms;
    end else if (k < 97) c.command = CMD_POP;
    else c.command = 3'($urandom_range(5, 7));
    return c;
  endfunction

  function automatic cmd_item_t mk(logic [2:0] cmd, logic [31:0] id,
                                   logic [63:0] per, logic [63:0] t);
    cmd_item_t c;
    c.command = cmd; c.task_id = id; c.period = per; c.time_ms = t;
    return c;
  endfunction

  task automatic add_cmd(cmd_item_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) tbl_used[i] = 0;
    next_id = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, one-shot, saturation, full table, overflow
    add_cmd(mk(CMD_POP, 0, 0, 0));
    add_cmd(mk(CMD_GET, 32'hFFFF_FFFF, '1, '1));
    add_cmd(mk(CMD_REMOVE, 0, 0, 0));
    add_cmd(mk(3'd7, '1, '1, '1));
    add_cmd(mk(CMD_ADD, '1, 0, 5));
    add_cmd(mk(CMD_ADD, 0, '1, 0));
    add_cmd(mk(CMD_GET, 2, 0, 0));
    add_cmd(mk(CMD_UPDATE, 0, 0, 10));
    add_cmd(mk(CMD_POP, 0, 0, 0));
    add_cmd(mk(CMD_POP, 0, 0, 0));
    add_cmd(mk(CMD_GET, 2, 0, 0));
    add_cmd(mk(CMD_REMOVE, 2, 0, 0));
    for (int i = 0; i < 17; i++) add_cmd(mk(CMD_ADD, 0, 1, 0));
    for (int i = 0; i < 3; i++) add_cmd(mk(CMD_UPDATE, 0, 0, '1));
    add_cmd(mk(CMD_POP, 0, 0, 0));
    wait_drained();
    for (int i = 3; i < 20; i++) add_cmd(mk(CMD_REMOVE, i, 0, 0));
    while (pending_cmds.size() < 60) add_cmd(mk(CMD_POP, 0, 0, 0));
    wait_drained();

    // receiver holds off while the sender keeps offering
    for (int i = 0; i < 6; i++) add_cmd(rand_cmd());
    hold_recv = 1;
    repeat (300) @(posedge clk);
    hold_recv = 0;
    wait_drained();

    send_idle_pct = 13; recv_idle_pct = 58;
    for (int i = 0; i < 167; i++) add_cmd(rand_cmd());
    wait_drained();
    send_idle_pct = 58; recv_idle_pct = 13;
    for (int i = 0; i < 167; i++) add_cmd(rand_cmd());
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 167; i++) add_cmd(rand_cmd());
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Ran %0d command transactions, %0d results checked (all commands,",
             accepted, replies_seen);
    $display("  full table, queue overflow/empty, saturation, id misses).");
    if (errors == 0 && expected_replies.size() == 0)
      $display("tb_periodic_task_timer_table_core: done, clean");
    else
      $display("tb_periodic_task_timer_table_core: done, errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_periodic_task_timer_table_core: done, errors");
    $finish;
  end
endmodule
